FILE: src/bdpc_pkg.sv
// bdpc_pkg: shared constants and types for the button debounce press classifier
// used by bdpc_core, bdpc_queue and button_debounce_press_classifier
`timescale 1ns / 1ps
`default_nettype none

package bdpc_pkg;

	localparam int MAX_EVENTS    = 6;
	localparam int THR_SLOTS     = 6;
	localparam int TIMER_BITS    = 16;
	localparam int DEBOUNCE_BITS = 8;
	localparam int CODE_BITS     = 3;
	localparam int COUNT_BITS    = 3;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;
	localparam int QUEUE_DEPTH   = 2;

	// the effective number of event codes is the smaller of these two
	localparam int EVENT_LIMIT = (MAX_EVENTS < THR_SLOTS) ? MAX_EVENTS : THR_SLOTS;

	// configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_REPORT_MODE = 3'd0,
		REG_DEBOUNCE    = 3'd1,
		REG_EVENT_COUNT = 3'd2,
		REG_THR_1       = 3'd3,
		REG_THR_2       = 3'd4,
		REG_THR_3       = 3'd5,
		REG_THR_4       = 3'd6,
		REG_THR_5       = 3'd7
	} cfg_reg_t;

	localparam logic MODE_HELD    = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	typedef struct packed {
		logic                                    report_mode;
		logic [DEBOUNCE_BITS-1:0]                debounce_ticks;
		logic [COUNT_BITS-1:0]                   event_count;
		logic [THR_SLOTS-1:0][TIMER_BITS-1:0]    thr;
	} cfg_t;

	// all results of one tick: fired events by code, plus status and key state
	typedef struct packed {
		logic [EVENT_LIMIT-1:0] ev_mask;
		logic [CODE_BITS-1:0]   code;
		logic                   key;
	} burst_t;

endpackage

`default_nettype wire

FILE: src/button_debounce_press_classifier.sv
// button_debounce_press_classifier: top level with configuration registers
// depends on bdpc_pkg, bdpc_core and bdpc_queue
`timescale 1ns / 1ps
`default_nettype none

// One raw pin sample per input beat. Each tick is classified in the cycle it
// is accepted (parallel threshold compares), so a tick can be taken every
// cycle. A tick yields one to five result beats; they wait in a two-entry
// burst queue and leave one per cycle while m_tready is high, so a tick
// with n results takes n output beats; the input stalls only when both queue
// entries are occupied. Configuration is written through cfg_we/cfg_addr/
// cfg_wdata and must only change while no results are pending.
module button_debounce_press_classifier
	import bdpc_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	input  wire logic [7:0]               s_tdata,   // [0] pin_level
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	output logic [7:0]                    m_tdata,   // [2:0] event_code, [3] key_is_set
	output logic                          m_tuser,   // [0] event_valid
	output logic                          m_tlast,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]  cfg_addr,
	input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata
);

	cfg_t                 cfg_q;
	burst_t               burst;
	logic                 tick;
	logic                 not_full;
	logic [CODE_BITS-1:0] out_code;
	logic                 out_key;

	assign s_tready = not_full;
	assign tick     = s_tvalid && not_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.report_mode    <= MODE_HELD;
			cfg_q.debounce_ticks <= DEBOUNCE_BITS'(5);
			cfg_q.event_count    <= COUNT_BITS'(2);
			cfg_q.thr[0]         <= '0;
			cfg_q.thr[1]         <= TIMER_BITS'(5);
			cfg_q.thr[2]         <= TIMER_BITS'(60);
			cfg_q.thr[3]         <= TIMER_BITS'(65535);
			cfg_q.thr[4]         <= TIMER_BITS'(65535);
			cfg_q.thr[5]         <= TIMER_BITS'(65535);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_REPORT_MODE: cfg_q.report_mode    <= cfg_wdata[0];
				REG_DEBOUNCE:    cfg_q.debounce_ticks <= cfg_wdata[DEBOUNCE_BITS-1:0];
				REG_EVENT_COUNT: cfg_q.event_count    <= cfg_wdata[COUNT_BITS-1:0];
				REG_THR_1:       cfg_q.thr[1]         <= cfg_wdata[TIMER_BITS-1:0];
				REG_THR_2:       cfg_q.thr[2]         <= cfg_wdata[TIMER_BITS-1:0];
				REG_THR_3:       cfg_q.thr[3]         <= cfg_wdata[TIMER_BITS-1:0];
				REG_THR_4:       cfg_q.thr[4]         <= cfg_wdata[TIMER_BITS-1:0];
				REG_THR_5:       cfg_q.thr[5]         <= cfg_wdata[TIMER_BITS-1:0];
				default: ;
			endcase
		end
	end

	bdpc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.tick   (tick),
		.pin    (s_tdata[0]),
		.burst  (burst)
	);

	bdpc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (tick),
		.push_burst (burst),
		.not_full   (not_full),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_event  (m_tuser),
		.out_code   (out_code),
		.out_key    (out_key),
		.out_last   (m_tlast)
	);

	assign m_tdata = {4'b0000, out_key, out_code};

endmodule

`default_nettype wire

FILE: src/bdpc_core.sv
// bdpc_core: debounce, press timer and event classifier for one tick per beat
// depends on bdpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bdpc_core
	import bdpc_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire cfg_t   cfg,
	input  wire logic   tick,
	input  wire logic   pin,
	output burst_t      burst
);

	logic                     sampled_q;
	logic [DEBOUNCE_BITS-1:0] stable_q;
	logic                     held_q;
	logic [TIMER_BITS-1:0]    press_q;
	logic                     key_q;
	logic [CODE_BITS-1:0]     cur_q;

	logic [DEBOUNCE_BITS-1:0] stable_n;
	logic                     held_n;
	logic [TIMER_BITS-1:0]    press_inc;
	logic [TIMER_BITS-1:0]    press_n;
	logic                     key_n;
	logic [CODE_BITS-1:0]     cur_n;
	logic [EVENT_LIMIT-1:0]   fire;
	logic [COUNT_BITS-1:0]    cnt_eff;
	logic [EVENT_LIMIT-1:0]   in_use;
	logic [EVENT_LIMIT-1:0]   passed;

	always_comb begin
		if (cfg.event_count > COUNT_BITS'(EVENT_LIMIT)) begin
			cnt_eff = COUNT_BITS'(EVENT_LIMIT);
		end else begin
			cnt_eff = cfg.event_count;
		end

		press_inc = (held_q && press_q != '1) ? press_q + 1'b1 : press_q;

		if (pin != sampled_q) begin
			stable_n = '0;
		end else if (stable_q != '1) begin
			stable_n = stable_q + 1'b1;
		end else begin
			stable_n = stable_q;
		end

		held_n  = held_q;
		press_n = press_inc;
		if (stable_n >= cfg.debounce_ticks) begin
			if (pin && !held_q) begin
				held_n  = 1'b1;
				press_n = '0;
			end
			if (!pin) begin
				held_n = 1'b0;
			end
		end

		// thresholds compared in parallel
		for (int k = 0; k < EVENT_LIMIT; k++) begin
			in_use[k] = (k >= 1) && (COUNT_BITS'(k) < cnt_eff);
			passed[k] = press_n >= cfg.thr[k];
		end

		fire  = '0;
		key_n = key_q;
		cur_n = cur_q;
		if (!key_q) begin
			if (held_n && press_n >= cfg.thr[1]) begin
				key_n = 1'b1;
				if (cfg.report_mode == MODE_HELD) begin
					cur_n   = CODE_BITS'(1);
					fire[1] = 1'b1;
				end
			end
		end else if (cfg.report_mode == MODE_HELD) begin
			if (!held_n) begin
				key_n   = 1'b0;
				cur_n   = '0;
				fire[0] = 1'b1;
			end else begin
				for (int k = 2; k < EVENT_LIMIT; k++) begin
					if (in_use[k] && passed[k] && cur_q < CODE_BITS'(k)) begin
						fire[k] = 1'b1;
						cur_n   = CODE_BITS'(k);
					end
				end
			end
		end else begin
			if (!held_n) begin
				key_n = 1'b0;
				for (int k = 1; k < EVENT_LIMIT; k++) begin
					if (in_use[k] && passed[k]) begin
						fire[k] = 1'b1;
						cur_n   = CODE_BITS'(k);
					end
				end
			end
		end

		burst.ev_mask = fire;
		burst.code    = cur_n;
		burst.key     = key_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sampled_q <= 1'b0;
			stable_q  <= '0;
			held_q    <= 1'b0;
			press_q   <= '0;
			key_q     <= 1'b0;
			cur_q     <= '0;
		end else if (tick) begin
			sampled_q <= pin;
			stable_q  <= stable_n;
			held_q    <= held_n;
			press_q   <= press_n;
			key_q     <= key_n;
			cur_q     <= cur_n;
		end
	end

`ifndef SYNTHESIS
	// state moves only on an accepted tick
	a_press_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!tick |=> $stable(press_q) && $stable(key_q) && $stable(cur_q))
		else $error("press state changed without a tick");

	// the key can only become set while a hold is running
	a_key_needs_hold: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(key_q) |-> held_q)
		else $error("key set without a hold");

	// a release event always leaves the key clear and the current code at zero
	a_release_clears: assert property (@(posedge clk) disable iff (!arst_n)
		tick && burst.ev_mask[0] |=> !key_q && cur_q == '0)
		else $error("release event left key set");
`endif

endmodule

`default_nettype wire

FILE: src/bdpc_queue.sv
// bdpc_queue: two-entry queue of per-tick result bursts, drained one result per beat
// depends on bdpc_pkg
`timescale 1ns / 1ps
`default_nettype none

module bdpc_queue
	import bdpc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire burst_t             push_burst,
	output logic                    not_full,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic                    out_event,
	output logic [CODE_BITS-1:0]    out_code,
	output logic                    out_key,
	output logic                    out_last
);

	localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

	burst_t                 ent_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0]    wr_ptr_q;
	logic [PTR_BITS-1:0]    rd_ptr_q;
	logic [CNT_BITS-1:0]    cnt_q;
	logic [EVENT_LIMIT-1:0] done_q;

	burst_t                 head;
	logic [EVENT_LIMIT-1:0] rem;
	logic [EVENT_LIMIT-1:0] low_bit;
	logic                   pop_beat;
	logic                   pop;

	assign not_full  = cnt_q != CNT_BITS'(QUEUE_DEPTH);
	assign out_valid = cnt_q != '0;
	assign head      = ent_q[rd_ptr_q];
	assign rem       = head.ev_mask & ~done_q;

	// lowest pending event code goes out first
	always_comb begin
		out_code = head.code;
		low_bit  = '0;
		for (int k = EVENT_LIMIT - 1; k >= 0; k--) begin
			if (rem[k]) begin
				out_code = CODE_BITS'(k);
				low_bit  = '0;
				low_bit[k] = 1'b1;
			end
		end
		out_event = rem != '0;
		out_key   = head.key;
		out_last  = (rem & (rem - 1'b1)) == '0;
	end

	assign pop_beat = out_valid && out_ready;
	assign pop      = pop_beat && out_last;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_burst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			done_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
				done_q   <= '0;
			end else if (pop_beat) begin
				done_q <= done_q | low_bit;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_BITS'(QUEUE_DEPTH))
		else $error("burst queue overfilled");

	// progress marks stay inside the head burst
	a_done_subset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (done_q & ~head.ev_mask) == '0)
		else $error("progress mask outside head burst");

	// finishing a burst with no push frees one entry
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("queue count did not drop on pop");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> not_full)
		else $error("push into full queue");
`endif

endmodule

`default_nettype wire
